// ===== src/tournament_branch_predictor_unit_assert.svh =====
// assertion macros for the tournament branch predictor unit
`ifndef TOURNAMENT_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked by i_clk, off while i_rst_n is low
`define TBP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked by i_clk, off while i_rst_n is low
`define TBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tbp_pkg.sv =====
// shared constants, types and index functions of the tournament branch predictor
package tbp_pkg;

    localparam int MAX_BIMODAL_BITS = 12;
    localparam int MAX_GSHARE_BITS  = 12;
    localparam int MAX_CHOOSER_BITS = 12;
    localparam int PC_WIDTH         = 32;
    localparam int CNT_W            = 32;

    localparam int BIM_AW = MAX_BIMODAL_BITS;
    localparam int GSH_AW = MAX_GSHARE_BITS;
    localparam int CHO_AW = MAX_CHOOSER_BITS;
    localparam int CLR_AW = (BIM_AW > GSH_AW) ?
                            ((BIM_AW > CHO_AW) ? BIM_AW : CHO_AW) :
                            ((GSH_AW > CHO_AW) ? GSH_AW : CHO_AW);

    localparam int IN_TDATA_W  = ((PC_WIDTH + 2 + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 + 2 * CNT_W + 7) / 8) * 8;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 4;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BIM_BITS  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GSH_BITS  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_HIST_BITS = 3'd3;
    localparam logic [CFG_AW-1:0] REG_CHO_BITS  = 3'd4;

    // mode codes, code three acts as hybrid
    localparam logic [1:0] MODE_BIMODAL = 2'd0;
    localparam logic [1:0] MODE_GSHARE  = 2'd1;
    localparam logic [1:0] MODE_HYBRID  = 2'd2;

    // register reset values
    localparam logic [1:0]        RST_MODE      = MODE_HYBRID;
    localparam logic [CFG_DW-1:0] RST_BIM_BITS  = 4'd12;
    localparam logic [CFG_DW-1:0] RST_GSH_BITS  = 4'd12;
    localparam logic [CFG_DW-1:0] RST_HIST_BITS = 4'd8;
    localparam logic [CFG_DW-1:0] RST_CHO_BITS  = 4'd12;

    typedef logic [1:0] t_ctr;
    typedef logic [4:0] t_bits;

    // table contents after reset
    localparam t_ctr BIM_RST = 2'd3;
    localparam t_ctr GSH_RST = 2'd2;
    localparam t_ctr CHO_RST = 2'd1;

    typedef enum logic {ST_CLEAR, ST_RUN} t_state;

    function automatic t_bits clamp_bits(input logic [CFG_DW-1:0] v, input t_bits hi);
        if (v == '0) begin
            return t_bits'(1);
        end
        if ({1'b0, v} > hi) begin
            return hi;
        end
        return {1'b0, v};
    endfunction

    function automatic t_ctr ctr_train(input t_ctr c, input logic taken);
        if (taken) begin
            return (c == 2'd3) ? c : c + 2'd1;
        end
        return (c == 2'd0) ? c : c - 2'd1;
    endfunction

    // history length, limited to the gshare index width
    function automatic t_bits hist_len(input logic [CFG_DW-1:0] gb,
                                       input logic [CFG_DW-1:0] hb);
        t_bits m;
        m = clamp_bits(gb, t_bits'(MAX_GSHARE_BITS));
        return ({1'b0, hb} > m) ? m : {1'b0, hb};
    endfunction

    // upper n of m pc bits xor history, low m-n bits pass through
    function automatic logic [GSH_AW-1:0] gsh_index(input logic [GSH_AW-1:0] pcl,
                                                    input logic [GSH_AW-1:0] hist,
                                                    input logic [CFG_DW-1:0] gb,
                                                    input logic [CFG_DW-1:0] hb);
        t_bits             m;
        t_bits             lo;
        logic [GSH_AW-1:0] mm;
        logic [GSH_AW-1:0] lm;
        logic [GSH_AW-1:0] pcm;
        logic [GSH_AW-1:0] x;
        m   = clamp_bits(gb, t_bits'(MAX_GSHARE_BITS));
        lo  = m - hist_len(gb, hb);
        mm  = ~({GSH_AW{1'b1}} << m);
        lm  = ~({GSH_AW{1'b1}} << lo);
        pcm = pcl & mm;
        x   = (pcm >> lo) ^ (hist & mm);
        return ((x << lo) | (pcm & lm)) & mm;
    endfunction

    // outcome enters at bit n-1, nothing enters when n is zero
    function automatic logic [GSH_AW-1:0] hist_shift(input logic [GSH_AW-1:0] hist,
                                                     input logic taken,
                                                     input logic [CFG_DW-1:0] gb,
                                                     input logic [CFG_DW-1:0] hb);
        t_bits             n;
        logic [GSH_AW-1:0] h;
        n = hist_len(gb, hb);
        h = hist >> 1;
        if (taken && (n != '0)) begin
            h = h | (GSH_AW'(1) << (n - t_bits'(1)));
        end
        return h;
    endfunction

endpackage

// ===== src/tbp_ram.sv =====
// simple dual-port ram with registered read, old data on same-address collision
module tbp_ram #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 2
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/tournament_branch_predictor_unit.sv =====
// top level of the tournament branch predictor: bimodal, gshare and chooser tables
//
//  channel  | dir | handshake                     | content
//  ---------+-----+-------------------------------+----------------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | branch pc, actual outcome, update flag
//  m_axis   | out | m_axis_tvalid / m_axis_tready | prediction, miss flag, both totals
//  cfg      | in  | i_cfg_we                      | mode, index and history widths, write only
//
// one item per cycle while the output is not stalled; the tables are read in the
// accept cycle, and predict and write-back happen as the item leaves the predict
// stage for the output register. the write-back of one item and the read of the
// following one may hit the same entry, so the written value is caught and forwarded
// into the next item. after reset a clearing pass over all 2^12 = 4096 addresses
// loads every table entry with its reset value; s_axis_tready stays low until it ends.
// a stalled output holds its item; one more item may wait in the predict stage.
module tournament_branch_predictor_unit
    import tbp_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_AW-1:0]      i_cfg_addr,
    input  logic [CFG_DW-1:0]      i_cfg_wdata,
    // branch items in
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] branch_pc, [32] actual_taken, [33] update_enable, rest zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // result items out
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] predicted_taken, [1] mispredicted, [33:2] prediction_count,
    // [65:34] mispredict_count, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // configuration registers
    logic [1:0]        r_mode;
    logic [CFG_DW-1:0] r_bim_bits;
    logic [CFG_DW-1:0] r_gsh_bits;
    logic [CFG_DW-1:0] r_hist_bits;
    logic [CFG_DW-1:0] r_cho_bits;

    // clearing sequencer
    t_state            r_state;
    t_state            n_state;
    logic [CLR_AW-1:0] r_clr_addr;
    logic              clr_active;

    // global history and totals
    logic [GSH_AW-1:0] r_hist;
    logic [CNT_W-1:0]  r_branch_total;
    logic [CNT_W-1:0]  r_miss_total;

    // predict stage
    logic              r_s1_valid;
    logic              r_s1_taken;
    logic              r_s1_upd;
    logic [BIM_AW-1:0] r_s1_bidx;
    logic [GSH_AW-1:0] r_s1_gidx;
    logic [CHO_AW-1:0] r_s1_cidx;
    logic              r_fwd_b;
    logic              r_fwd_g;
    logic              r_fwd_c;
    t_ctr              r_fwd_b_data;
    t_ctr              r_fwd_g_data;
    t_ctr              r_fwd_c_data;

    // output register, the totals travel with it
    logic              r_out_valid;
    logic              r_out_pred;
    logic              r_out_miss;

    // accept side
    logic                    in_acc;
    logic                    s1_free;
    logic                    s1_adv;
    logic [PC_WIDTH-1:0]     in_pc;
    logic                    in_taken;
    logic                    in_upd;
    logic [PC_WIDTH-3:0]     pcw;
    logic [BIM_AW-1:0]       bim_mask;
    logic [CHO_AW-1:0]       cho_mask;
    logic [BIM_AW-1:0]       bidx;
    logic [GSH_AW-1:0]       gidx;
    logic [CHO_AW-1:0]       cidx;

    // predict side
    t_ctr              b_rdata;
    t_ctr              g_rdata;
    t_ctr              c_rdata;
    t_ctr              b_cnt;
    t_ctr              g_cnt;
    t_ctr              c_cnt;
    logic              hyb;
    logic              bpred;
    logic              gpred;
    logic              use_g;
    logic              pred;
    logic              miss;
    logic              miss_cnt;
    logic              b_upd;
    logic              g_upd;
    logic              c_upd;

    // table write ports
    logic              b_we;
    logic              g_we;
    logic              c_we;
    logic [BIM_AW-1:0] b_waddr;
    logic [GSH_AW-1:0] g_waddr;
    logic [CHO_AW-1:0] c_waddr;
    t_ctr              b_wdata;
    t_ctr              g_wdata;
    t_ctr              c_wdata;

    // configuration writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= RST_MODE;
            r_bim_bits  <= RST_BIM_BITS;
            r_gsh_bits  <= RST_GSH_BITS;
            r_hist_bits <= RST_HIST_BITS;
            r_cho_bits  <= RST_CHO_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:      r_mode      <= i_cfg_wdata[1:0];
                REG_BIM_BITS:  r_bim_bits  <= i_cfg_wdata;
                REG_GSH_BITS:  r_gsh_bits  <= i_cfg_wdata;
                REG_HIST_BITS: r_hist_bits <= i_cfg_wdata;
                REG_CHO_BITS:  r_cho_bits  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // clearing pass: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == {CLR_AW{1'b1}}) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN:   n_state = ST_RUN;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // clearing pass: outputs
    always_comb begin
        case (r_state)
            ST_CLEAR: clr_active = 1'b1;
            ST_RUN:   clr_active = 1'b0;
            default:  clr_active = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (clr_active) begin
                r_clr_addr <= r_clr_addr + CLR_AW'(1);
            end
        end
    end

    // handshake: the predict stage moves when the output register is free
    assign s1_free       = !r_out_valid || m_axis_tready;
    assign s1_adv        = r_s1_valid && s1_free;
    assign s_axis_tready = !clr_active && (!r_s1_valid || s1_free);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // input fields
    assign in_pc    = s_axis_tdata[PC_WIDTH-1:0];
    assign in_taken = s_axis_tdata[PC_WIDTH];
    assign in_upd   = s_axis_tdata[PC_WIDTH+1];
    assign pcw      = in_pc[PC_WIDTH-1:2];

    // table indexes, widths clamped to the table sizes
    assign bim_mask = ~({BIM_AW{1'b1}} << clamp_bits(r_bim_bits, t_bits'(MAX_BIMODAL_BITS)));
    assign cho_mask = ~({CHO_AW{1'b1}} << clamp_bits(r_cho_bits, t_bits'(MAX_CHOOSER_BITS)));
    assign bidx     = pcw[BIM_AW-1:0] & bim_mask;
    assign cidx     = pcw[CHO_AW-1:0] & cho_mask;
    assign gidx     = gsh_index(pcw[GSH_AW-1:0], r_hist, r_gsh_bits, r_hist_bits);

    // history moves at accept, except in bimodal mode: the outcome is known with the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
        end else if (in_acc && (r_mode != MODE_BIMODAL)) begin
            r_hist <= hist_shift(r_hist, in_taken, r_gsh_bits, r_hist_bits);
        end
    end

    // predict stage, with write-back catch for a same-cycle hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_taken   <= in_taken;
            r_s1_upd     <= in_upd;
            r_s1_bidx    <= bidx;
            r_s1_gidx    <= gidx;
            r_s1_cidx    <= cidx;
            r_fwd_b      <= b_we && (b_waddr == bidx);
            r_fwd_g      <= g_we && (g_waddr == gidx);
            r_fwd_c      <= c_we && (c_waddr == cidx);
            r_fwd_b_data <= b_wdata;
            r_fwd_g_data <= g_wdata;
            r_fwd_c_data <= c_wdata;
        end
    end

    assign b_cnt = r_fwd_b ? r_fwd_b_data : b_rdata;
    assign g_cnt = r_fwd_g ? r_fwd_g_data : g_rdata;
    assign c_cnt = r_fwd_c ? r_fwd_c_data : c_rdata;

    // prediction and training decisions
    always_comb begin
        hyb   = r_mode[1];
        bpred = b_cnt[1];
        gpred = g_cnt[1];
        use_g = c_cnt[1];
        if (hyb) begin
            pred = use_g ? gpred : bpred;
        end else if (r_mode == MODE_GSHARE) begin
            pred = gpred;
        end else begin
            pred = bpred;
        end
        miss     = pred ^ r_s1_taken;
        // single modes count misses only when training is enabled
        miss_cnt = miss && (hyb || r_s1_upd);
        b_upd    = s1_adv && ((r_mode == MODE_BIMODAL && r_s1_upd) || (hyb && !use_g));
        g_upd    = s1_adv && ((r_mode == MODE_GSHARE && r_s1_upd) || (hyb && use_g));
        // chooser moves only when exactly one predictor was right
        c_upd    = s1_adv && hyb && (gpred != bpred);
    end

    // table write ports: clearing pass or training write-back
    always_comb begin
        if (clr_active) begin
            b_we    = 1'b1;
            g_we    = 1'b1;
            c_we    = 1'b1;
            b_waddr = r_clr_addr[BIM_AW-1:0];
            g_waddr = r_clr_addr[GSH_AW-1:0];
            c_waddr = r_clr_addr[CHO_AW-1:0];
            b_wdata = BIM_RST;
            g_wdata = GSH_RST;
            c_wdata = CHO_RST;
        end else begin
            b_we    = b_upd;
            g_we    = g_upd;
            c_we    = c_upd;
            b_waddr = r_s1_bidx;
            g_waddr = r_s1_gidx;
            c_waddr = r_s1_cidx;
            b_wdata = ctr_train(b_cnt, r_s1_taken);
            g_wdata = ctr_train(g_cnt, r_s1_taken);
            c_wdata = ctr_train(c_cnt, gpred == r_s1_taken);
        end
    end

    tbp_ram #(
        .ADDR_W (BIM_AW),
        .DATA_W (2)
    ) u_bim_ram (
        .i_clk     (i_clk),
        .i_wr_en   (b_we),
        .i_wr_addr (b_waddr),
        .i_wr_data (b_wdata),
        .i_rd_en   (in_acc),
        .i_rd_addr (bidx),
        .o_rd_data (b_rdata)
    );

    tbp_ram #(
        .ADDR_W (GSH_AW),
        .DATA_W (2)
    ) u_gsh_ram (
        .i_clk     (i_clk),
        .i_wr_en   (g_we),
        .i_wr_addr (g_waddr),
        .i_wr_data (g_wdata),
        .i_rd_en   (in_acc),
        .i_rd_addr (gidx),
        .o_rd_data (g_rdata)
    );

    tbp_ram #(
        .ADDR_W (CHO_AW),
        .DATA_W (2)
    ) u_cho_ram (
        .i_clk     (i_clk),
        .i_wr_en   (c_we),
        .i_wr_addr (c_waddr),
        .i_wr_data (c_wdata),
        .i_rd_en   (in_acc),
        .i_rd_addr (cidx),
        .o_rd_data (c_rdata)
    );

    // totals change only when an item moves into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_branch_total <= '0;
            r_miss_total   <= '0;
        end else if (s1_adv) begin
            r_branch_total <= r_branch_total + CNT_W'(1);
            if (miss_cnt) begin
                r_miss_total <= r_miss_total + CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_pred <= pred;
            r_out_miss <= miss;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 - 2 * CNT_W){1'b0}},
                            r_miss_total, r_branch_total, r_out_miss, r_out_pred};

`include "tournament_branch_predictor_unit_assert.svh"

    `TBP_ASSERT_IMPL(a_no_item_in_clear, clr_active, !r_s1_valid && !r_out_valid, "item in flight during clearing pass")
    `TBP_ASSERT_NEXT(a_accept_fills_s1, in_acc, r_s1_valid, "accepted item lost before predict stage")
    `TBP_ASSERT_NEXT(a_total_hold, !s1_adv, $stable(r_branch_total), "branch total moved without an item")
    `TBP_ASSERT_NEXT(a_total_step, s1_adv, r_branch_total == $past(r_branch_total) + CNT_W'(1), "branch total missed an item")

endmodule
